/* hdl/fca_pkg.sv */
// Shared constants, codes and types of the block-link table allocator.
`default_nettype none
package fca_pkg;

   localparam int NUM_BLOCKS = 128;
   localparam int END_MARK   = 255;

   localparam int FUNC_W = 3;
   localparam int IDX_W  = 7;
   localparam int VAL_W  = 8;
   localparam int STAT_W = 2;
   localparam int ADDR_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

   localparam logic [FUNC_W-1:0] FN_READ  = 3'd0;
   localparam logic [FUNC_W-1:0] FN_WRITE = 3'd1;
   localparam logic [FUNC_W-1:0] FN_ALLOC = 3'd2;
   localparam logic [FUNC_W-1:0] FN_LINK  = 3'd3;
   localparam logic [FUNC_W-1:0] FN_FREE  = 3'd4;

   localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
   localparam logic [STAT_W-1:0] ST_LOOP = 2'd2;

   localparam logic [VAL_W-1:0] END_VAL  = VAL_W'(END_MARK);
   localparam logic [VAL_W-1:0] NUM_VAL  = VAL_W'(NUM_BLOCKS);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_BLOCKS - 1);

   // finished result handed from the engine to the output register
   typedef struct packed {
      logic              valid;
      logic [VAL_W-1:0]  value;
      logic [STAT_W-1:0] status;
   } result_type;

   // table memory access from the engine
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [VAL_W-1:0]  wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

endpackage
`default_nettype wire

/* hdl/fca_req_if.sv */
// Request channel: valid/ready handshake with the request fields.
`default_nettype none
interface fca_req_if;
   import fca_pkg::*;

   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [IDX_W-1:0]  block_index;
   logic [VAL_W-1:0]  entry_value;

   modport source (output valid, func, block_index, entry_value, input ready);
   modport sink   (input valid, func, block_index, entry_value, output ready);
endinterface
`default_nettype wire

/* hdl/fca_rsp_if.sv */
// Response channel: valid/ready handshake with the result fields.
`default_nettype none
interface fca_rsp_if;
   import fca_pkg::*;

   logic              valid;
   logic              ready;
   logic [VAL_W-1:0]  result_value;
   logic [STAT_W-1:0] status;

   modport source (output valid, result_value, status, input ready);
   modport sink   (input valid, result_value, status, output ready);
endinterface
`default_nettype wire

/* hdl/fca_ram.sv */
// Generic simple dual-port RAM with registered read.
`default_nettype none
module fca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

/* hdl/fca_engine.sv */
// Request sequencer: table clear, lookup, free-block scan and chain walk.
`default_nettype none
module fca_engine (
   input  wire logic                  clock,
   input  wire logic                  reset,
   fca_req_if.sink                    req_ch,
   output fca_pkg::result_type        res,
   input  wire logic                  res_take,
   output fca_pkg::mem_req_type       mem,
   input  wire logic [fca_pkg::VAL_W-1:0] mem_rdata
);
   import fca_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_READ, S_SCAN, S_LINK, S_WALK_RD, S_WALK_CHK, S_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [FUNC_W-1:0] func_ff, func_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic              pend_ff, pend_in;
   logic [ADDR_W-1:0] pend_addr_ff, pend_addr_in;
   logic [ADDR_W-1:0] blk_ff, blk_in;
   logic [VAL_W-1:0]  cur_ff, cur_in;
   logic [VAL_W-1:0]  steps_ff, steps_in;
   logic [VAL_W-1:0]  value_ff, value_in;
   logic [STAT_W-1:0] status_ff, status_in;

   logic accept;
   logic req_in_range;
   logic idx_in_range;
   logic cur_in_range;
   logic scan_hit;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign req_in_range = {1'b0, req_ch.block_index} < NUM_VAL;
   assign idx_in_range = {1'b0, idx_ff} < NUM_VAL;
   assign cur_in_range = cur_ff < NUM_VAL;

   // entry under test is free and is not the block being linked after
   assign scan_hit = pend_ff && (mem_rdata == '0) &&
                     !((func_ff == FN_LINK) && (VAL_W'(pend_addr_ff) == VAL_W'(idx_ff)));

   assign res.valid  = (state_ff == S_DONE);
   assign res.value  = value_ff;
   assign res.status = status_ff;

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      idx_in       = idx_ff;
      ptr_in       = ptr_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      blk_in       = blk_ff;
      cur_in       = cur_ff;
      steps_in     = steps_ff;
      value_in     = value_ff;
      status_in    = status_ff;
      mem          = '0;

      unique case (state_ff)
         S_CLEAR: begin
            mem.wr_en   = 1'b1;
            mem.wr_addr = ptr_ff;
            if (ptr_ff == LAST_ADDR) begin
               ptr_in   = '0;
               state_in = S_IDLE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (accept) begin
               func_in   = req_ch.func;
               idx_in    = req_ch.block_index;
               value_in  = '0;
               status_in = ST_OK;
               state_in  = S_DONE;
               case (req_ch.func) inside
                  FN_READ: begin
                     if (req_in_range) begin
                        mem.rd_en   = 1'b1;
                        mem.rd_addr = ADDR_W'(req_ch.block_index);
                        state_in    = S_READ;
                     end
                  end
                  FN_WRITE: begin
                     mem.wr_en   = req_in_range;
                     mem.wr_addr = ADDR_W'(req_ch.block_index);
                     mem.wr_data = req_ch.entry_value;
                  end
                  FN_ALLOC, FN_LINK: begin
                     ptr_in   = '0;
                     pend_in  = 1'b0;
                     state_in = S_SCAN;
                  end
                  FN_FREE: begin
                     cur_in   = {1'b0, req_ch.block_index};
                     steps_in = '0;
                     state_in = S_WALK_RD;
                  end
                  default: ;
               endcase
            end
         end
         S_READ: begin
            value_in = mem_rdata;
            state_in = S_DONE;
         end
         S_SCAN: begin
            // one read issued per cycle, its data checked in the next cycle
            mem.rd_en    = 1'b1;
            mem.rd_addr  = ptr_ff;
            pend_in      = 1'b1;
            pend_addr_in = ptr_ff;
            if (ptr_ff != LAST_ADDR) begin
               ptr_in = ptr_ff + 1'b1;
            end
            if (scan_hit) begin
               mem.wr_en   = 1'b1;
               mem.wr_addr = pend_addr_ff;
               mem.wr_data = END_VAL;
               blk_in      = pend_addr_ff;
               value_in    = VAL_W'(pend_addr_ff);
               status_in   = ST_OK;
               state_in    = ((func_ff == FN_LINK) && idx_in_range) ? S_LINK : S_DONE;
            end else if (pend_ff && (pend_addr_ff == LAST_ADDR)) begin
               value_in  = '0;
               status_in = ST_FULL;
               state_in  = S_DONE;
            end
         end
         S_LINK: begin
            mem.wr_en   = 1'b1;
            mem.wr_addr = ADDR_W'(idx_ff);
            mem.wr_data = VAL_W'(blk_ff);
            state_in    = S_DONE;
         end
         S_WALK_RD: begin
            value_in = steps_ff;
            if (cur_ff == END_VAL) begin
               status_in = ST_OK;
               state_in  = S_DONE;
            end else if (!cur_in_range || (steps_ff >= NUM_VAL)) begin
               status_in = ST_LOOP;
               state_in  = S_DONE;
            end else begin
               mem.rd_en   = 1'b1;
               mem.rd_addr = cur_ff[ADDR_W-1:0];
               state_in    = S_WALK_CHK;
            end
         end
         S_WALK_CHK: begin
            if (mem_rdata == '0) begin
               value_in  = steps_ff;
               status_in = ST_LOOP;
               state_in  = S_DONE;
            end else begin
               mem.wr_en   = 1'b1;
               mem.wr_addr = cur_ff[ADDR_W-1:0];
               mem.wr_data = '0;
               cur_in      = mem_rdata;
               steps_in    = steps_ff + 1'b1;
               state_in    = S_WALK_RD;
            end
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         ptr_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
         pend_ff  <= pend_in;
      end
      func_ff      <= func_in;
      idx_ff       <= idx_in;
      pend_addr_ff <= pend_addr_in;
      blk_ff       <= blk_in;
      cur_ff       <= cur_in;
      steps_ff     <= steps_in;
      value_ff     <= value_in;
      status_ff    <= status_in;
   end
endmodule
`default_nettype wire

/* hdl/fca_rsp_reg.sv */
// Output register between the engine and the response channel.
`default_nettype none
module fca_rsp_reg (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire fca_pkg::result_type res,
   output logic                     res_take,
   fca_rsp_if.source                rsp_ch
);
   import fca_pkg::*;

   logic              valid_ff;
   logic [VAL_W-1:0]  value_ff;
   logic [STAT_W-1:0] status_ff;

   assign res_take = !valid_ff || rsp_ch.ready;

   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.result_value = value_ff;
   assign rsp_ch.status       = status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (res_take) begin
         valid_ff <= res.valid;
      end
      if (res_take && res.valid) begin
         value_ff  <= res.value;
         status_ff <= res.status;
      end
   end
endmodule
`default_nettype wire

/* hdl/fat_chain_allocator.sv */
// Top level of the block-link table allocator.
`default_nettype none
// Keeps a table of NUM_BLOCKS block links (0 free, END_MARK last block of
// a chain, else the next block) in one synchronous RAM and serves one
// request item at a time: read an entry, write an entry, allocate the first
// free block as a chain end, allocate and link after a given block, or free
// a whole chain. Each request gives exactly one response item. After reset
// the table is swept to zero, one entry per cycle, and requests are refused
// until the sweep is done. The single RAM port pair and its registered read
// set the steps of each item: a read looks the entry up and then returns it;
// an allocate scans the entries upward from block 0 and stops at the first
// free block or the last one, then links if asked; a free walks the chain,
// each link read and then cleared. An output register holds a finished
// item, so the next request is taken while the response waits; the engine
// only stalls at the end of that next request.
module fat_chain_allocator (
   input  wire logic clock,
   input  wire logic reset,
   fca_req_if.sink   req_ch,
   fca_rsp_if.source rsp_ch
);
   import fca_pkg::*;

   result_type       res;
   logic             res_take;
   mem_req_type      mem;
   logic [VAL_W-1:0] mem_rdata;

   // sequencer: drives the RAM and holds all per-item bookkeeping
   fca_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .res       (res),
      .res_take  (res_take),
      .mem       (mem),
      .mem_rdata (mem_rdata)
   );

   // link table
   fca_ram #(
      .WIDTH (VAL_W),
      .DEPTH (NUM_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem.wr_en),
      .wr_addr (mem.wr_addr),
      .wr_data (mem.wr_data),
      .rd_en   (mem.rd_en),
      .rd_addr (mem.rd_addr),
      .rd_data (mem_rdata)
   );

   // response holding register
   fca_rsp_reg u_rsp_reg (
      .clock    (clock),
      .reset    (reset),
      .res      (res),
      .res_take (res_take),
      .rsp_ch   (rsp_ch)
   );
endmodule
`default_nettype wire

/* hdl/fca_checker.sv */
// Port-level checks of the allocator and their binding to the top level.
`default_nettype none
module fca_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_ready,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic [fca_pkg::VAL_W-1:0]  rsp_result_value,
   input wire logic [fca_pkg::STAT_W-1:0] rsp_status
);
   import fca_pkg::*;

   // items taken but not yet answered
   logic [1:0] outst_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         outst_ff <= '0;
      end else begin
         outst_ff <= outst_ff + 2'((req_valid && req_ready) ? 1 : 0)
                              - 2'((rsp_valid && rsp_ready) ? 1 : 0);
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_result_value) && $stable(rsp_status))
      else $error("stalled response changed");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outst_ff != 2'd0)
      else $error("response without a pending request");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      outst_ff != 2'd3)
      else $error("more than two requests in flight");

   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL) |-> rsp_result_value == '0)
      else $error("failed allocation returned a block");
endmodule

bind fat_chain_allocator fca_checker u_fca_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_result_value (rsp_ch.result_value),
   .rsp_status       (rsp_ch.status)
);
`default_nettype wire
